### rtl/core/pte_pkg.sv
`default_nettype none

package pte_pkg;

    localparam int DEF_TABLE_FRAMES = 64;
    localparam int IDX_W            = 9;
    localparam int ENTRIES          = 1 << IDX_W;
    localparam int LEVELS           = 4;
    localparam int VPN_W            = IDX_W * LEVELS;
    localparam int OFFSET_W         = 12;
    localparam int VA_W             = 48;
    localparam int PA_W             = 52;
    localparam int ENTRY_W          = 64;
    localparam int ENTRY_ADDR_W     = PA_W - OFFSET_W;
    localparam int PRESENT_BIT      = 0;
    localparam logic [OFFSET_W-1:0] ENTRY_PTR_FLAGS = 12'h003;
    localparam logic [1:0] LAST_LEVEL = 2'(LEVELS - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_TRANSLATE = 2'd0;
    localparam logic [1:0] REQ_MAP       = 2'd1;
    localparam logic [1:0] REQ_UNMAP     = 2'd2;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_MAPPED    = 2'd1,
        ST_MISALIGNED    = 2'd2,
        ST_OUT_OF_TABLES = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        K_TRANSLATE  = 3'd0,
        K_MAP        = 3'd1,
        K_UNMAP      = 3'd2,
        K_MISALIGNED = 3'd3,
        K_NOP        = 3'd4
    } item_kind_t;

    typedef struct packed {
        item_kind_t                kind;
        logic [VPN_W-1:0]          vpn;
        logic [OFFSET_W-1:0]       offset;
        logic [ENTRY_W-1:0]        leaf;
    } item_t;

endpackage

`default_nettype wire

### rtl/core/pte_front.sv
`default_nettype none

module pte_front
    import pte_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               hold,
    input  wire logic [1:0]         req_type,
    input  wire logic [VA_W-1:0]    vaddr,
    input  wire logic [PA_W-1:0]    paddr,
    input  wire logic [ENTRY_W-1:0] leaf_flags,
    output logic                    busy,
    output logic                    push,
    output item_t                   push_item,
    input  wire logic               q_full
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign busy   = hold | (valid_reg & q_full);
    assign accept = start & ~busy;
    assign push   = valid_reg & ~q_full;
    assign push_item = item_reg;

    always_comb
    begin
        item_next        = item_reg;
        item_next.vpn    = vaddr[VA_W-1:OFFSET_W];
        item_next.offset = vaddr[OFFSET_W-1:0];
        item_next.leaf   = {{(ENTRY_W-PA_W){1'b0}}, paddr} | leaf_flags;
        case (req_type)
            REQ_TRANSLATE: item_next.kind = K_TRANSLATE;
            REQ_MAP:       item_next.kind = K_MAP;
            REQ_UNMAP:
            begin
                // An unmap of an address inside a page is marked misaligned here.
                if (vaddr[OFFSET_W-1:0] != '0)
                    item_next.kind = K_MISALIGNED;
                else
                    item_next.kind = K_UNMAP;
            end
            default:       item_next.kind = K_NOP;
        endcase
    end

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

### rtl/core/pte_queue.sv
`default_nettype none

module pte_queue
    import pte_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output item_t      head_item
);

    item_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg;
    logic [QUEUE_CW-1:0]  count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & ~empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### rtl/core/pte_back.sv
`default_nettype none

module pte_back
    import pte_pkg::*;
#(
    parameter int TABLE_FRAMES = DEF_TABLE_FRAMES
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_empty,
    input  wire item_t     q_item,
    output logic           q_pop,
    output logic           clearing,
    output logic           done,
    output logic [1:0]     status,
    output logic [PA_W-1:0] phys_out
);

    localparam int FW    = $clog2(TABLE_FRAMES);
    localparam int AW    = FW + IDX_W;
    localparam int DEPTH = TABLE_FRAMES * ENTRIES;
    localparam int NW    = $clog2(TABLE_FRAMES + 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EVAL  = 4'b1000
    } state_t;

    logic [ENTRY_W-1:0] mem [DEPTH];

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    item_t              item_reg, item_next;
    logic [1:0]         level_reg, level_next;
    logic [FW-1:0]      frame_reg, frame_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [NW-1:0]      nff_reg, nff_next;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [PA_W-1:0]    phys_reg, phys_next;

    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   idx;

    assign clearing = (state_reg == S_CLEAR);
    assign done     = done_reg;
    assign status   = status_reg;
    assign phys_out = phys_reg;

    always_comb
    begin
        case (level_reg)
            2'd0:    idx = item_reg.vpn[4*IDX_W-1:3*IDX_W];
            2'd1:    idx = item_reg.vpn[3*IDX_W-1:2*IDX_W];
            2'd2:    idx = item_reg.vpn[2*IDX_W-1:IDX_W];
            default: idx = item_reg.vpn[IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        item_next   = item_reg;
        level_next  = level_reg;
        frame_next  = frame_reg;
        addr_next   = addr_reg;
        nff_next    = nff_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        phys_next   = phys_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = addr_reg;
        mem_raddr   = {frame_reg, idx};
        mem_wdata   = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    level_next = '0;
                    frame_next = '0;
                    case (q_item.kind)
                        K_MISALIGNED:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_MISALIGNED;
                            phys_next   = '0;
                        end
                        K_NOP:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            phys_next   = '0;
                        end
                        default: state_next = S_READ;
                    endcase
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                addr_next  = mem_raddr;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                phys_next = '0;
                if (level_reg != LAST_LEVEL)
                begin
                    if (rdata_reg[PRESENT_BIT])
                    begin
                        if (rdata_reg[PA_W-1:OFFSET_W] >= ENTRY_ADDR_W'(TABLE_FRAMES))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOT_MAPPED;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            frame_next = rdata_reg[OFFSET_W +: FW];
                            level_next = level_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    else if (item_reg.kind == K_MAP)
                    begin
                        if (nff_reg >= NW'(TABLE_FRAMES))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OUT_OF_TABLES;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            // Hand out the next zeroed frame and link it in.
                            mem_we     = 1'b1;
                            mem_wdata  = ENTRY_W'({nff_reg, ENTRY_PTR_FLAGS});
                            frame_next = nff_reg[FW-1:0];
                            nff_next   = nff_reg + 1'b1;
                            level_next = level_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        // A missing level is a miss for translate, a no-op for unmap.
                        done_next   = 1'b1;
                        status_next = (item_reg.kind == K_UNMAP) ? ST_OK : ST_NOT_MAPPED;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    case (item_reg.kind)
                        K_TRANSLATE:
                        begin
                            if (rdata_reg[PRESENT_BIT])
                            begin
                                status_next = ST_OK;
                                phys_next   = {rdata_reg[PA_W-1:OFFSET_W], item_reg.offset};
                            end
                            else
                                status_next = ST_NOT_MAPPED;
                        end
                        K_MAP:
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = item_reg.leaf;
                            status_next = ST_OK;
                        end
                        default:
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = '0;
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            level_reg <= '0;
            frame_reg <= '0;
            nff_reg   <= NW'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            level_reg <= level_next;
            frame_reg <= frame_next;
            nff_reg   <= nff_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        phys_reg   <= phys_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/four_level_page_table_engine_core.sv
`default_nettype none

// Channel   | Direction | Signals                                           | Handshake
// ----------+-----------+---------------------------------------------------+---------------------
// request   | in        | req_type, vaddr, paddr, leaf_flags                | start high, busy low
// result    | out       | status, phys_out                                  | done, one-cycle strobe
//
// After reset the table store is cleared one entry a cycle, with busy held high.
// A request then passes through the front stage register and the queue, and each of the
// four table levels takes a memory read (S_READ) and then a decode (S_EVAL).
// A misaligned unmap or an unknown request type is answered from the idle state without
// a table walk. The result receiver cannot stall; busy rises while the table is cleared
// and while the queue and the front stage are both full.

module four_level_page_table_engine_core
    import pte_pkg::*;
#(
    parameter int TABLE_FRAMES = DEF_TABLE_FRAMES
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic [VA_W-1:0]    vaddr,
    input  wire logic [PA_W-1:0]    paddr,
    input  wire logic [ENTRY_W-1:0] leaf_flags,
    output logic                    done,
    output logic [1:0]              status,
    output logic [PA_W-1:0]         phys_out
);

    logic  clearing;
    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    item_t q_item;

    pte_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .hold       (clearing),
        .req_type   (req_type),
        .vaddr      (vaddr),
        .paddr      (paddr),
        .leaf_flags (leaf_flags),
        .busy       (busy),
        .push       (push),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    pte_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (q_item)
    );

    pte_back #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .done     (done),
        .status   (status),
        .phys_out (phys_out)
    );

    a_no_result_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !done)
        else $error("result strobe during table clearing");

    a_clear_runs_once : assert property (@(posedge clk) disable iff (!rst_n)
        !clearing |=> !clearing)
        else $error("table clearing restarted without reset");

    a_phys_zero_on_error : assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (phys_out == '0))
        else $error("nonzero address returned with an error status");

    a_no_pop_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("item taken from the queue during table clearing");

endmodule

`default_nettype wire

### sim/pte_walk_checker.sv
`default_nettype none

module pte_walk_checker
    import pte_pkg::*;
#(
    parameter int TABLE_FRAMES = DEF_TABLE_FRAMES
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         req_type,
    input  wire logic [VA_W-1:0]    vaddr,
    input  wire logic [PA_W-1:0]    paddr,
    input  wire logic [ENTRY_W-1:0] leaf_flags,
    input  wire logic               done,
    input  wire logic [1:0]         status,
    input  wire logic [PA_W-1:0]    phys_out,
    output int                      fail_count,
    output int                      pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t         st;
        logic [PA_W-1:0] pa;
    } walk_result_t;

    logic [ENTRY_W-1:0] table_mem [TABLE_FRAMES*ENTRIES];
    int unsigned        alloc_next;
    walk_result_t       expected_results [$];
    walk_result_t       oldest;
    int                 mismatches = 0;

    assign fail_count = mismatches;

    function automatic int slot_of(int frame, logic [VA_W-1:0] va, int lvl);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(va >> (OFFSET_W + IDX_W * (LEVELS - 1 - lvl)));
        return frame * ENTRIES + int'(idx);
    endfunction

    // Walks the three upper levels; with grow set, missing tables come from the
    // bump allocator and stay in place even if a later level runs out of frames.
    function automatic status_t descend(logic [VA_W-1:0] va, bit grow, output int leaf_frame);
        int                      frame;
        int                      s;
        logic [ENTRY_W-1:0]      e;
        logic [ENTRY_ADDR_W-1:0] nxt;
        frame = 0;
        leaf_frame = 0;
        for (int lvl = 0; lvl < LEVELS - 1; lvl++)
        begin
            s = slot_of(frame, va, lvl);
            e = table_mem[s];
            if (e[PRESENT_BIT])
            begin
                nxt = e[PA_W-1:OFFSET_W];
                if (nxt >= TABLE_FRAMES)
                    return ST_NOT_MAPPED;
                frame = int'(nxt);
            end
            else
            begin
                if (!grow)
                    return ST_NOT_MAPPED;
                if (alloc_next >= TABLE_FRAMES)
                    return ST_OUT_OF_TABLES;
                frame = int'(alloc_next);
                alloc_next++;
                table_mem[s] = (ENTRY_W'(frame) << OFFSET_W) | ENTRY_W'(ENTRY_PTR_FLAGS);
            end
        end
        leaf_frame = frame;
        return ST_OK;
    endfunction

    function automatic walk_result_t predict_request(logic [1:0] req, logic [VA_W-1:0] va,
                                                     logic [PA_W-1:0] pa,
                                                     logic [ENTRY_W-1:0] flags);
        walk_result_t r;
        int           leaf;
        int           s;
        r.st = ST_OK;
        r.pa = '0;
        case (req)
            REQ_TRANSLATE:
            begin
                r.st = descend(va, 1'b0, leaf);
                if (r.st == ST_OK)
                begin
                    s = slot_of(leaf, va, LEVELS - 1);
                    if (table_mem[s][PRESENT_BIT])
                        r.pa = {table_mem[s][PA_W-1:OFFSET_W], va[OFFSET_W-1:0]};
                    else
                        r.st = ST_NOT_MAPPED;
                end
            end
            REQ_MAP:
            begin
                r.st = descend(va, 1'b1, leaf);
                if (r.st == ST_OK)
                    table_mem[slot_of(leaf, va, LEVELS - 1)] = ENTRY_W'(pa) | flags;
            end
            REQ_UNMAP:
            begin
                if (va[OFFSET_W-1:0] != '0)
                    r.st = ST_MISALIGNED;
                else if (descend(va, 1'b0, leaf) == ST_OK)
                    table_mem[slot_of(leaf, va, LEVELS - 1)] = '0;
            end
            default:
            begin
                // The reserved request type changes nothing and answers ok.
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_FRAMES * ENTRIES; i++)
                table_mem[i] = '0;
            alloc_next = 1;
            expected_results.delete();
            pending_count <= 0;
        end
        else
        begin
            // Results leave before this edge's item is predicted; no item can
            // answer at the edge that accepts it.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item outstanding: status %0d phys_out %h",
                           status, phys_out);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.st)
                    begin
                        $error("status: expected %0d, got %0d", oldest.st, status);
                        mismatches++;
                    end
                    if (phys_out !== oldest.pa)
                    begin
                        $error("phys_out: expected %h, got %h", oldest.pa, phys_out);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_request(req_type, vaddr,
                                                           paddr, leaf_flags));
            pending_count <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

### sim/tb_four_level_page_table_engine_core.sv
`default_nettype none

module tb_four_level_page_table_engine_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pte_pkg::*;

    localparam logic [1:0] REQ_RESERVED   = 2'd3;
    localparam int         WATCHDOG_LIMIT = 200000;
    localparam int         RANDOM_ITEMS   = 1700;
    localparam int         REGION_COUNT   = 8;
    localparam int         REGION_W       = VA_W - OFFSET_W - IDX_W;
    localparam int         PAGE_W         = VA_W - OFFSET_W;
    localparam int         MAPPED_KEEP    = 64;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         req_type = '0;
    logic [VA_W-1:0]    vaddr = '0;
    logic [PA_W-1:0]    paddr = '0;
    logic [ENTRY_W-1:0] leaf_flags = '0;
    wire                busy;
    wire                done;
    wire  [1:0]         status;
    wire  [PA_W-1:0]    phys_out;
    int                 fail_count;
    int                 pending_count;

    bit                 steady = 1'b0;
    logic [REGION_W-1:0] regions [REGION_COUNT];
    logic [PAGE_W-1:0]   mapped_pages [$];

    always #5 clk = ~clk;

    four_level_page_table_engine_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .vaddr      (vaddr),
        .paddr      (paddr),
        .leaf_flags (leaf_flags),
        .done       (done),
        .status     (status),
        .phys_out   (phys_out)
    );

    pte_walk_checker walk_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .vaddr         (vaddr),
        .paddr         (paddr),
        .leaf_flags    (leaf_flags),
        .done          (done),
        .status        (status),
        .phys_out      (phys_out),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Offers one item and returns at the edge that accepts it. Start stays high
    // from one item to the next unless an idle gap is drawn.
    task automatic issue(input logic [1:0] req, input logic [VA_W-1:0] va,
                         input logic [PA_W-1:0] pa, input logic [ENTRY_W-1:0] flags);
        if (!steady && $urandom_range(0, 99) < 17)
        begin
            repeat ($urandom_range(1, 4))
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= req;
        vaddr      <= va;
        paddr      <= pa;
        leaf_flags <= flags;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Most addresses land in a few regions so that tables get reused; the rest are
    // pages mapped earlier or fresh addresses that drain the frame allocator.
    function automatic logic [VA_W-1:0] pick_va(int fresh_pct);
        int              roll;
        logic [VA_W-1:0] va;
        roll = $urandom_range(0, 99);
        va = VA_W'({$urandom, $urandom});
        if (roll < 70)
        begin
            va[VA_W-1:OFFSET_W+IDX_W] = regions[$urandom_range(0, REGION_COUNT - 1)];
            va[OFFSET_W+IDX_W-1:OFFSET_W] = IDX_W'($urandom_range(0, 15));
        end
        else if (roll < 100 - fresh_pct && mapped_pages.size() > 0)
        begin
            va[VA_W-1:OFFSET_W] = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
        end
        return va;
    endfunction

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [IDX_W-1:0]   top_idx [2];
        logic [IDX_W-1:0]   mid_idx [3];
        logic [VA_W-1:0]    va;
        logic [ENTRY_W-1:0] flags;
        int                 roll;

        foreach (top_idx[i])
            top_idx[i] = IDX_W'($urandom);
        foreach (mid_idx[i])
            mid_idx[i] = IDX_W'($urandom);
        foreach (regions[i])
            regions[i] = {top_idx[$urandom_range(0, 1)], mid_idx[$urandom_range(0, 2)],
                          IDX_W'($urandom)};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table: translate misses, unmap of a missing level succeeds,
        // unaligned unmap is refused.
        issue(REQ_TRANSLATE, '0, '0, '0);
        issue(REQ_UNMAP, '0, '0, '0);
        issue(REQ_UNMAP, VA_W'(48'h123), '0, '0);
        // Unaligned physical address is stored as given.
        issue(REQ_MAP, '0, '1, ENTRY_W'(3));
        issue(REQ_TRANSLATE, VA_W'(48'hFFF), '0, '0);
        // Highest unaligned virtual address with every flag bit set.
        issue(REQ_MAP, '1, PA_W'(52'h1_2345_6789_A000), '1);
        issue(REQ_TRANSLATE, VA_W'(48'hFFFF_FFFF_F000), '0, '0);
        // Leaf written without the present bit reads back as not mapped.
        issue(REQ_MAP, VA_W'(48'h1000), PA_W'(52'h5000), ENTRY_W'(2));
        issue(REQ_TRANSLATE, VA_W'(48'h1ABC), '0, '0);
        issue(REQ_UNMAP, VA_W'(48'hFFFF_FFFF_F000), '0, '0);
        issue(REQ_TRANSLATE, VA_W'(48'hFFFF_FFFF_F123), '0, '0);
        // Shares the top-level table with address zero but misses below it.
        issue(REQ_TRANSLATE, VA_W'(48'h0000_4000_0000), '0, '0);
        issue(REQ_UNMAP, VA_W'(48'h0000_4000_0000), '0, '0);
        issue(REQ_RESERVED, '1, '1, '1);
        issue(REQ_MAP, '0, '0, ENTRY_W'(1));
        issue(REQ_TRANSLATE, VA_W'(48'h7FF), '0, '0);
        issue(REQ_UNMAP, '0, '0, '0);
        issue(REQ_TRANSLATE, '0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 700 && n < 1000);
            roll = $urandom_range(0, 99);
            if (roll < 36)
            begin
                va = pick_va(4);
                flags = {$urandom, $urandom};
                if ($urandom_range(0, 4) != 0)
                    flags &= 64'hFFF0_0000_0000_0FFF;
                if ($urandom_range(0, 99) < 85)
                    flags[PRESENT_BIT] = 1'b1;
                issue(REQ_MAP, va, PA_W'({$urandom, $urandom}), flags);
                mapped_pages.push_back(va[VA_W-1:OFFSET_W]);
                if (mapped_pages.size() > MAPPED_KEEP)
                    void'(mapped_pages.pop_front());
            end
            else if (roll < 72)
            begin
                issue(REQ_TRANSLATE, pick_va(12), PA_W'({$urandom, $urandom}),
                      {$urandom, $urandom});
            end
            else if (roll < 96)
            begin
                va = pick_va(12);
                if ($urandom_range(0, 99) < 85)
                    va[OFFSET_W-1:0] = '0;
                issue(REQ_UNMAP, va, PA_W'({$urandom, $urandom}), {$urandom, $urandom});
            end
            else
            begin
                issue(REQ_RESERVED, VA_W'({$urandom, $urandom}), PA_W'({$urandom, $urandom}),
                      {$urandom, $urandom});
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/core/pte_pkg.sv
rtl/core/pte_front.sv
rtl/core/pte_queue.sv
rtl/core/pte_back.sv
rtl/core/four_level_page_table_engine_core.sv
sim/pte_walk_checker.sv
sim/tb_four_level_page_table_engine_core.sv
